// ----- hdl/hamming_sec_codec_defines.svh -----
// ----------------------------------------------------------------------------
// hamming_sec_codec_defines.svh
// Assertion macros shared by the Hamming SEC codec.
// ----------------------------------------------------------------------------
`ifndef HAMMING_SEC_CODEC_DEFINES_SVH
`define HAMMING_SEC_CODEC_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define HSC_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("hsc: same-cycle check failed");

// check a condition a fixed number of cycles after its trigger
`define HSC_ASSERT_DELAY(label, clk, rst, trig, dly, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##dly (cond)) \
      else $error("hsc: delayed check failed");

`endif

// ----- hdl/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg
// Types, constants and helper functions of the Hamming SEC codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsc_pkg;

   localparam int MaxDataBytes = 7;
   localparam int WordWidth    = 62;
   localparam int PosWidth     = 6;
   localparam int CfgWidth     = 3;
   localparam int ParityBits   = 6;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic [WordWidth-1:0] word;
   } hsc_req_type;

   typedef struct packed {
      logic [WordWidth-1:0] result_word;
      logic [PosWidth-1:0]  error_position;
   } hsc_rsp_type;

   typedef struct packed {
      logic                 valid;
      logic                 operation;
      logic [PosWidth-1:0]  code_len;
      logic [WordWidth-1:0] bits;
   } hsc_beat_type;

   typedef struct packed {
      hsc_beat_type          beat;
      logic [ParityBits-1:0] syndrome;
   } hsc_syn_type;

   function automatic logic hsc_is_pow2(int v);
      return (v != 0) && ((v & (v - 1)) == 0);
   endfunction

   // data bits per row, zero and out-of-range settings clamped
   function automatic logic [PosWidth-1:0] hsc_data_len(logic [CfgWidth-1:0] db);
      logic [PosWidth-1:0] n;
      case (db)
         3'd0, 3'd1: n = 6'd8;
         3'd2:       n = 6'd16;
         3'd3:       n = 6'd24;
         3'd4:       n = 6'd32;
         3'd5:       n = 6'd40;
         3'd6:       n = 6'd48;
         3'd7:       n = 6'd56;
         default:    n = 6'd8;
      endcase
      return n;
   endfunction

   // codeword bits per row: data bits plus parity bits
   function automatic logic [PosWidth-1:0] hsc_code_len(logic [CfgWidth-1:0] db);
      logic [PosWidth-1:0] l;
      case (db)
         3'd0, 3'd1: l = 6'd12;
         3'd2:       l = 6'd21;
         3'd3:       l = 6'd29;
         3'd4:       l = 6'd38;
         3'd5:       l = 6'd46;
         3'd6:       l = 6'd54;
         3'd7:       l = 6'd62;
         default:    l = 6'd12;
      endcase
      return l;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/hsc_front.sv -----
// ----------------------------------------------------------------------------
// hsc_front
// Input stage: masks the row to its length and spreads data bits onto
// codeword positions for encode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire hsc_pkg::hsc_req_type      req_item,
   input  wire logic [hsc_pkg::CfgWidth-1:0] data_bytes,
   output hsc_pkg::hsc_beat_type          beat_out
);
   import hsc_pkg::*;

   logic [PosWidth-1:0]  data_len;
   logic [PosWidth-1:0]  code_len;
   logic [WordWidth-1:0] spread;
   logic [WordWidth-1:0] code_masked;
   hsc_beat_type         beat_in;
   hsc_beat_type         beat_ff;
   logic                 valid_ff;

   always_comb begin
      int d;
      data_len    = hsc_data_len(data_bytes);
      code_len    = hsc_code_len(data_bytes);
      spread      = '0;
      code_masked = '0;
      d = 0;
      for (int pos = 1; pos <= WordWidth; pos++) begin
         if (!hsc_is_pow2(pos)) begin
            if (6'(d) < data_len) begin
               spread[pos-1] = req_item.word[d];
            end
            d++;
         end
      end
      for (int i = 0; i < WordWidth; i++) begin
         code_masked[i] = req_item.word[i] & (6'(i) < code_len);
      end
      beat_in.valid     = 1'b1;
      beat_in.operation = req_item.operation;
      beat_in.code_len  = code_len;
      beat_in.bits      = (req_item.operation == OP_DECODE) ? code_masked : spread;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         beat_ff <= beat_in;
      end
   end

   always_comb begin
      beat_out       = beat_ff;
      beat_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

// ----- hdl/hsc_syndrome.sv -----
// ----------------------------------------------------------------------------
// hsc_syndrome
// Parity stage: XOR trees over each position group give the parity bits on
// encode and the syndrome on decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsc_syndrome (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hsc_pkg::hsc_beat_type beat_in,
   output hsc_pkg::hsc_syn_type       syn_out
);
   import hsc_pkg::*;

   logic [ParityBits-1:0] syndrome_in;
   hsc_syn_type           syn_ff;
   logic                  valid_ff;

   always_comb begin
      syndrome_in = '0;
      for (int k = 0; k < ParityBits; k++) begin
         for (int i = 0; i < WordWidth; i++) begin
            if ((((i + 1) >> k) & 1) != 0) begin
               syndrome_in[k] = syndrome_in[k] ^ beat_in.bits[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= beat_in.valid;
      end
      if (beat_in.valid) begin
         syn_ff.beat     <= beat_in;
         syn_ff.syndrome <= syndrome_in;
      end
   end

   always_comb begin
      syn_out            = syn_ff;
      syn_out.beat.valid = valid_ff;
   end

endmodule

`default_nettype wire

// ----- hdl/hsc_finish.sv -----
// ----------------------------------------------------------------------------
// hsc_finish
// Output stage: inserts parity bits on encode; flips the named bit and
// strips parity on decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsc_finish (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hsc_pkg::hsc_syn_type syn_in,
   output logic                      rsp_valid,
   output hsc_pkg::hsc_rsp_type      rsp_item
);
   import hsc_pkg::*;

   logic [WordWidth-1:0] coded;
   logic [WordWidth-1:0] fixed;
   logic [WordWidth-1:0] data;
   logic [PosWidth-1:0]  flip_idx;
   logic                 flip;
   hsc_rsp_type          rsp_in;
   hsc_rsp_type          rsp_ff;
   logic                 valid_ff;

   always_comb begin
      int d;
      coded = syn_in.beat.bits;
      for (int k = 0; k < ParityBits; k++) begin
         coded[(1 << k) - 1] = syn_in.syndrome[k];
      end

      flip_idx = syn_in.syndrome - 6'd1;
      flip     = (syn_in.syndrome != '0) && (syn_in.syndrome <= syn_in.beat.code_len);
      fixed    = syn_in.beat.bits;
      if (flip) begin
         fixed[flip_idx] = ~fixed[flip_idx];
      end

      data = '0;
      d = 0;
      for (int pos = 1; pos <= WordWidth; pos++) begin
         if (!hsc_is_pow2(pos)) begin
            data[d] = fixed[pos-1];
            d++;
         end
      end

      if (syn_in.beat.operation == OP_DECODE) begin
         rsp_in.result_word    = data;
         rsp_in.error_position = syn_in.syndrome;
      end else begin
         rsp_in.result_word    = coded;
         rsp_in.error_position = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= syn_in.beat.valid;
      end
      if (syn_in.beat.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ----- hdl/hamming_sec_codec.sv -----
// ----------------------------------------------------------------------------
// hamming_sec_codec
// Hamming single-error-correcting codec, one row of 8 to 56 data bits a beat.
// ----------------------------------------------------------------------------
// A beat taken on accept passes the front, parity and finish registers to rsp_valid.
// Throughput: one beat per cycle, set by the three-stage front/parity/finish
// pipeline; busy is high during reset and the cycle right after it, low otherwise.
// Reset: clears all pipeline valid bits, drops any beat in flight and sets
// data_bytes to 1.
`timescale 1ns / 1ps
`default_nettype none
`include "hamming_sec_codec_defines.svh"

module hamming_sec_codec (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire hsc_pkg::hsc_req_type         req_item,
   output logic                              rsp_valid,
   output hsc_pkg::hsc_rsp_type              rsp_item,
   input  wire logic                         csr_wr_en,
   input  wire logic [hsc_pkg::CfgWidth-1:0] csr_wr_data
);
   import hsc_pkg::*;

   logic [CfgWidth-1:0] data_bytes_ff;
   logic                busy_ff;
   logic                accept;
   hsc_beat_type        front_beat;
   hsc_syn_type         syn_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bytes_ff <= 3'd1;
         busy_ff       <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr_en) begin
            data_bytes_ff <= csr_wr_data;
         end
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   hsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_item   (req_item),
      .data_bytes (data_bytes_ff),
      .beat_out   (front_beat)
   );

   hsc_syndrome u_syndrome (
      .clock   (clock),
      .reset   (reset),
      .beat_in (front_beat),
      .syn_out (syn_beat)
   );

   hsc_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .syn_in    (syn_beat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   `HSC_ASSERT_DELAY(a_latency, clock, reset, accept, 3, rsp_valid)
   `HSC_ASSERT_NOW(a_encode_no_error, clock, reset, rsp_valid && $past(accept && req_item.operation == OP_ENCODE, 3), rsp_item.error_position == '0)
   `HSC_ASSERT_NOW(a_decode_width, clock, reset, rsp_valid && $past(accept && req_item.operation == OP_DECODE, 3), rsp_item.result_word[61:56] == '0)

endmodule

`default_nettype wire
